FILE: design/biped_gait_joint_position_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gait generator
// BGJP_ASSERT is gated by reset; BGJP_ASSERT_ANY also checks while in reset.
// ----------------------------------------------------------------------------
`ifndef BIPED_GAIT_JOINT_POSITION_GENERATOR_ASSERT_SVH
`define BIPED_GAIT_JOINT_POSITION_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BGJP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BGJP_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BGJP_ASSERT(lbl, prop, msg)
`define BGJP_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

FILE: design/bgjp_pkg.sv
// ----------------------------------------------------------------------------
// bgjp_pkg
// Types, widths and constant tables of the gait joint position generator.
// ----------------------------------------------------------------------------
package bgjp_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned LEN_W      = 14;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PHASE_W    = 4;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned NUM_SEG    = 3;

  localparam int unsigned SQ_W    = 32;
  localparam int unsigned FAC_W   = 18;
  localparam int unsigned SPROD_W = 50;
  localparam int unsigned SMOOTH_W = 17;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned MUL_W   = 36;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned Z_W     = 21;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned PROD_W  = 48;
  localparam int unsigned SEG_W   = 17;
  localparam int unsigned WIDE_W  = 28;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_LAT   = CORDIC_STEPS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 3'd0,
    REG_STRIDE = 3'd1,
    REG_BODY_X = 3'd2,
    REG_FLOOR  = 3'd3,
    REG_HIP_H  = 3'd4,
    REG_THIGH  = 3'd5,
    REG_SHANK  = 3'd6,
    REG_FOOT   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin;
    logic signed [TRIG_W-1:0] cos;
  } trig_t;

  // phase ends in thousandths of a cycle; the last phase ends at 1.0
  localparam int BOUND_MILLI [NUM_PHASES-1] = '{50, 120, 300, 450, 550, 650, 800, 920, 970};

  localparam int ATAN_Q16 [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [Z_W-1:0]    HALF_PI     = 21'sd102944;
  localparam logic signed [Z_W-1:0]    PI_Z        = 21'sd205887;

  localparam logic signed [WIDE_W-1:0] POS_MAX_W = 28'sd8388607;
  localparam logic signed [WIDE_W-1:0] POS_MIN_W = -28'sd8388608;

  // [phase][thigh, shank, foot][start, end], 1/8192 rad
  localparam int ANGLE_TAB [NUM_PHASES][NUM_SEG][2] = '{
    '{'{-819, -2458}, '{410, 1638}, '{-1638, 819}},
    '{'{-2458, 819}, '{1638, -1638}, '{819, 1638}},
    '{'{819, 3277}, '{-1638, -3277}, '{1638, 2458}},
    '{'{3277, 1638}, '{-3277, 1638}, '{2458, 4915}},
    '{'{1638, -4096}, '{1638, 0}, '{4915, -6554}},
    '{'{-4096, -1638}, '{0, -4915}, '{-6554, 1638}},
    '{'{-1638, 1638}, '{-4915, 0}, '{1638, -1638}},
    '{'{1638, -819}, '{0, 819}, '{-1638, -3277}},
    '{'{-819, -1229}, '{819, 1229}, '{-3277, -2458}},
    '{'{-1229, -819}, '{1229, 410}, '{-2458, -1638}}
  };

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
    if (v > POS_MAX_W) begin
      sat_pos = POS_MAX_W[POS_W-1:0];
    end else if (v < POS_MIN_W) begin
      sat_pos = POS_MIN_W[POS_W-1:0];
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

FILE: design/bgjp_if.sv
// ----------------------------------------------------------------------------
// bgjp_in_if / bgjp_out_if
// Valid/ready channels for time samples and joint position results.
// ----------------------------------------------------------------------------
interface bgjp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_us;
  logic        left_leg;

  modport source (output valid, output time_us, output left_leg, input ready);
  modport sink (input valid, input time_us, input left_leg, output ready);
endinterface

interface bgjp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] hip_x;
  logic signed [23:0] hip_y;
  logic signed [23:0] knee_x;
  logic signed [23:0] knee_y;
  logic signed [23:0] ankle_x;
  logic signed [23:0] ankle_y;
  logic signed [23:0] toe_x;
  logic signed [23:0] toe_y;
  logic [3:0]         gait_phase;
  logic [15:0]        phase_fraction;

  modport source (output valid, output hip_x, output hip_y, output knee_x, output knee_y,
                  output ankle_x, output ankle_y, output toe_x, output toe_y,
                  output gait_phase, output phase_fraction, input ready);
  modport sink (input valid, input hip_x, input hip_y, input knee_x, input knee_y,
                input ankle_x, input ankle_y, input toe_x, input toe_y,
                input gait_phase, input phase_fraction, output ready);
endinterface

FILE: design/biped_gait_joint_position_generator.sv
// ----------------------------------------------------------------------------
// biped_gait_joint_position_generator
// Time sample to gait phase, joint angles and leg joint coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one time sample (time_us, left_leg) per transaction; out_ch
//   returns one result per sample, in order: hip, knee, ankle and toe
//   coordinates (1/4096 m, saturated to 24 bits), gait_phase and
//   phase_fraction.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
//   pipeline is empty; a write takes effect on the next clock.
//   A sample can enter every cycle unless the receiver stalls; the depth
//   is set by the bit-per-stage restoring divider (32 remainder bits, then
//   FRACTION_BITS quotient bits), the 16-bit phase fraction divider and the
//   17-stage CORDIC units.
//   Reset clears all valid bits and loads the default gait registers.
//   When the receiver stalls, the whole pipeline holds; in_ch.ready drops
//   only while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module biped_gait_joint_position_generator #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bgjp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bgjp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  bgjp_in_if.sink                             in_ch,
  bgjp_out_if.source                          out_ch
);

`include "biped_gait_joint_position_generator_assert.svh"

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned BW   = F + 1;
  localparam int unsigned NDIV = bgjp_pkg::TIME_W + F;
  localparam int unsigned NFR  = bgjp_pkg::FRAC_W;
  localparam int unsigned LAT  = NDIV + NFR + 5 + bgjp_pkg::CORDIC_LAT + 4;

  function automatic logic [BW-1:0] bound_of(input int i);
    if (i >= bgjp_pkg::NUM_PHASES - 1) begin
      bound_of = {1'b1, {F{1'b0}}};
    end else begin
      bound_of = BW'(((longint'(bgjp_pkg::BOUND_MILLI[i]) << F) + 500) / 1000);
    end
  endfunction

  function automatic logic [BW-1:0] start_of(input int i);
    if (i == 0) begin
      start_of = '0;
    end else begin
      start_of = bound_of(i - 1);
    end
  endfunction

  function automatic logic [F-1:0] den_of(input int i);
    den_of = F'(bound_of(i) - start_of(i));
  endfunction

  localparam logic [BW-1:0] BOUND [bgjp_pkg::NUM_PHASES] = '{
    bound_of(0), bound_of(1), bound_of(2), bound_of(3), bound_of(4),
    bound_of(5), bound_of(6), bound_of(7), bound_of(8), bound_of(9)
  };
  localparam logic [BW-1:0] START [bgjp_pkg::NUM_PHASES] = '{
    start_of(0), start_of(1), start_of(2), start_of(3), start_of(4),
    start_of(5), start_of(6), start_of(7), start_of(8), start_of(9)
  };
  localparam logic [F-1:0] DEN [bgjp_pkg::NUM_PHASES] = '{
    den_of(0), den_of(1), den_of(2), den_of(3), den_of(4),
    den_of(5), den_of(6), den_of(7), den_of(8), den_of(9)
  };

  typedef struct packed {
    logic                                left;
    logic [bgjp_pkg::TIME_W-1:0]         num;
    logic [bgjp_pkg::PERIOD_W-1:0]       rem;
    logic [F-1:0]                        q;
  } div1_t;

  typedef struct packed {
    logic                                left;
    logic [bgjp_pkg::PHASE_W-1:0]        idx;
    logic [F-1:0]                        den;
    logic [F-1:0]                        rem;
    logic [bgjp_pkg::FRAC_W-1:0]         q;
  } div2_t;

  typedef struct packed {
    logic                                left;
    logic [bgjp_pkg::PHASE_W-1:0]        idx;
    logic [bgjp_pkg::FRAC_W-1:0]         frac;
  } side_t;

  typedef struct packed {
    side_t                               sd;
    logic [bgjp_pkg::SQ_W-1:0]           sq;
  } sm1_t;

  typedef struct packed {
    side_t                               sd;
    logic [bgjp_pkg::SPROD_W-1:0]        prod;
  } sm2_t;

  typedef struct packed {
    side_t                               sd;
    logic [bgjp_pkg::SMOOTH_W-1:0]       s;
  } sm3_t;

  typedef logic signed [bgjp_pkg::ANG_W-1:0] ang_t;
  typedef logic signed [bgjp_pkg::Z_W-1:0]   zang_t;
  typedef logic signed [bgjp_pkg::SEG_W-1:0] seg_t;
  typedef logic signed [bgjp_pkg::WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [bgjp_pkg::POS_W-1:0]   hip_x;
    logic signed [bgjp_pkg::POS_W-1:0]   hip_y;
    logic signed [bgjp_pkg::POS_W-1:0]   knee_x;
    logic signed [bgjp_pkg::POS_W-1:0]   knee_y;
    logic signed [bgjp_pkg::POS_W-1:0]   ankle_x;
    logic signed [bgjp_pkg::POS_W-1:0]   ankle_y;
    logic signed [bgjp_pkg::POS_W-1:0]   toe_x;
    logic signed [bgjp_pkg::POS_W-1:0]   toe_y;
    logic [bgjp_pkg::PHASE_W-1:0]        phase;
    logic [bgjp_pkg::FRAC_W-1:0]         frac;
  } res_t;

  // configuration registers
  logic [bgjp_pkg::PERIOD_W-1:0]     period_q;
  logic [bgjp_pkg::LEN_W-1:0]        stride_q;
  logic signed [bgjp_pkg::POS_W-1:0] body_x_q;
  logic signed [bgjp_pkg::POS_W-1:0] floor_q;
  logic [bgjp_pkg::LEN_W-1:0]        hip_h_q;
  logic [bgjp_pkg::LEN_W-1:0]        thigh_q;
  logic [bgjp_pkg::LEN_W-1:0]        shank_q;
  logic [bgjp_pkg::LEN_W-1:0]        foot_q;

  // a zero period is stored as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 24'd909091;
      stride_q <= 14'd2662;
      body_x_q <= '0;
      floor_q  <= '0;
      hip_h_q  <= 14'd3768;
      thigh_q  <= 14'd1925;
      shank_q  <= 14'd1843;
      foot_q   <= 14'd1024;
    end else if (cfg_we_i) begin
      unique case (bgjp_pkg::cfg_reg_e'(cfg_idx_i))
        bgjp_pkg::REG_PERIOD: period_q <= (cfg_data_i == '0) ? 24'd1 : cfg_data_i;
        bgjp_pkg::REG_STRIDE: stride_q <= cfg_data_i[bgjp_pkg::LEN_W-1:0];
        bgjp_pkg::REG_BODY_X: body_x_q <= cfg_data_i;
        bgjp_pkg::REG_FLOOR:  floor_q  <= cfg_data_i;
        bgjp_pkg::REG_HIP_H:  hip_h_q  <= cfg_data_i[bgjp_pkg::LEN_W-1:0];
        bgjp_pkg::REG_THIGH:  thigh_q  <= cfg_data_i[bgjp_pkg::LEN_W-1:0];
        bgjp_pkg::REG_SHANK:  shank_q  <= cfg_data_i[bgjp_pkg::LEN_W-1:0];
        bgjp_pkg::REG_FOOT:   foot_q   <= cfg_data_i[bgjp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: everything moves together unless the output is stuck
  logic           adv;
  logic           in_fire;
  logic [LAT-1:0] vld_q;

  assign adv     = !vld_q[LAT-1] || out_ch.ready;
  assign in_fire = in_ch.valid && adv;
  assign in_ch.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_fire};
    end
  end

  // time mod period, then (rem << F) / period, one quotient bit per stage
  div1_t div1_q [NDIV];
  div1_t div1_d [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_div1
    div1_t                       src;
    logic [bgjp_pkg::PERIOD_W:0] tr;
    logic [bgjp_pkg::PERIOD_W:0] dif;
    logic                        ge;

    if (k == 0) begin : g_first
      assign src = '{left: in_ch.left_leg, num: in_ch.time_us, rem: '0, q: '0};
    end else begin : g_next
      assign src = div1_q[k-1];
    end

    assign tr  = {src.rem, src.num[bgjp_pkg::TIME_W-1]};
    assign ge  = (tr >= {1'b0, period_q});
    assign dif = tr - {1'b0, period_q};

    always_comb begin
      div1_d[k].left = src.left;
      div1_d[k].num  = {src.num[bgjp_pkg::TIME_W-2:0], 1'b0};
      div1_d[k].rem  = ge ? dif[bgjp_pkg::PERIOD_W-1:0] : tr[bgjp_pkg::PERIOD_W-1:0];
      div1_d[k].q    = {src.q[F-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div1_q <= div1_d;
    end
  end

  // phase classification; the left leg's half-cycle shift flips the MSB
  logic [F-1:0]                      ph;
  logic [bgjp_pkg::NUM_PHASES-2:0]   ge_vec;
  logic [bgjp_pkg::PHASE_W-1:0]      idx;
  logic [BW-1:0]                     off;
  div2_t                             cls_d;
  div2_t                             div2_q [NFR+1];
  div2_t                             div2_d [NFR];

  always_comb begin
    ph = {div1_q[NDIV-1].q[F-1] ^ div1_q[NDIV-1].left, div1_q[NDIV-1].q[F-2:0]};
    for (int i = 0; i < bgjp_pkg::NUM_PHASES - 1; i++) begin
      ge_vec[i] = ({1'b0, ph} >= BOUND[i]);
    end
    idx = bgjp_pkg::PHASE_W'($countones(ge_vec));
    off = {1'b0, ph} - START[idx];
    cls_d.left = div1_q[NDIV-1].left;
    cls_d.idx  = idx;
    cls_d.den  = DEN[idx];
    cls_d.rem  = off[F-1:0];
    cls_d.q    = '0;
  end

  // ((ph - start) << 16) / den, one bit per stage
  for (genvar k = 0; k < NFR; k++) begin : g_div2
    logic [F:0] tr;
    logic [F:0] dif;
    logic       ge;

    assign tr  = {div2_q[k].rem, 1'b0};
    assign ge  = (tr >= {1'b0, div2_q[k].den});
    assign dif = tr - {1'b0, div2_q[k].den};

    always_comb begin
      div2_d[k]     = div2_q[k];
      div2_d[k].rem = ge ? dif[F-1:0] : tr[F-1:0];
      div2_d[k].q   = {div2_q[k].q[bgjp_pkg::FRAC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div2_q[0] <= cls_d;
      for (int i = 1; i <= NFR; i++) begin
        div2_q[i] <= div2_d[i-1];
      end
    end
  end

  // smoothstep s = round(f^2 * (3*2^16 - 2f) / 2^32)
  side_t                          fr_sd;
  sm1_t                           sm1_q;
  sm2_t                           sm2_q;
  sm3_t                           sm3_q;
  logic [bgjp_pkg::FAC_W-1:0]     fac;
  logic [bgjp_pkg::SPROD_W-1:0]   rnd;

  assign fr_sd = '{left: div2_q[NFR].left, idx: div2_q[NFR].idx, frac: div2_q[NFR].q};
  assign fac   = 18'd196608 - {1'b0, sm1_q.sd.frac, 1'b0};
  assign rnd   = sm2_q.prod + (50'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm1_q.sd   <= fr_sd;
      sm1_q.sq   <= bgjp_pkg::SQ_W'(fr_sd.frac) * bgjp_pkg::SQ_W'(fr_sd.frac);
      sm2_q.sd   <= sm1_q.sd;
      sm2_q.prod <= bgjp_pkg::SPROD_W'(sm1_q.sq) * bgjp_pkg::SPROD_W'(fac);
      sm3_q.sd   <= sm2_q.sd;
      sm3_q.s    <= rnd[32 +: bgjp_pkg::SMOOTH_W];
    end
  end

  // angle interpolation per segment, then the running angle sums
  side_t sm4_sd_q;
  ang_t  ang_q [bgjp_pkg::NUM_SEG];
  ang_t  ang_d [bgjp_pkg::NUM_SEG];
  side_t sm5_sd_q;
  zang_t z_q [bgjp_pkg::NUM_SEG];

  for (genvar k = 0; k < bgjp_pkg::NUM_SEG; k++) begin : g_ang
    logic signed [bgjp_pkg::ANG_W-1:0]  a0;
    logic signed [bgjp_pkg::ANG_W-1:0]  a1;
    logic signed [bgjp_pkg::DIFF_W-1:0] d;
    logic signed [bgjp_pkg::MUL_W-1:0]  mp;
    logic signed [bgjp_pkg::MUL_W-1:0]  sh;

    assign a0 = bgjp_pkg::ANG_W'(bgjp_pkg::ANGLE_TAB[sm3_q.sd.idx][k][0]);
    assign a1 = bgjp_pkg::ANG_W'(bgjp_pkg::ANGLE_TAB[sm3_q.sd.idx][k][1]);
    assign d  = bgjp_pkg::DIFF_W'(a1) - bgjp_pkg::DIFF_W'(a0);
    assign mp = bgjp_pkg::MUL_W'(d) * $signed(bgjp_pkg::MUL_W'(sm3_q.s))
              + $signed(bgjp_pkg::MUL_W'(32768));
    assign sh = mp >>> 16;
    assign ang_d[k] = bgjp_pkg::ANG_W'(bgjp_pkg::MUL_W'(a0) + sh);
  end

  logic signed [bgjp_pkg::SUM_W-1:0] sum0;
  logic signed [bgjp_pkg::SUM_W-1:0] sum1;
  logic signed [bgjp_pkg::SUM_W-1:0] sum2;

  assign sum0 = bgjp_pkg::SUM_W'(ang_q[0]);
  assign sum1 = sum0 + bgjp_pkg::SUM_W'(ang_q[1]);
  assign sum2 = sum1 + bgjp_pkg::SUM_W'(ang_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm4_sd_q <= sm3_q.sd;
      ang_q    <= ang_d;
      sm5_sd_q <= sm4_sd_q;
      // 1/8192 rad to 1/65536 rad
      z_q[0]   <= bgjp_pkg::Z_W'(sum0) <<< 3;
      z_q[1]   <= bgjp_pkg::Z_W'(sum1) <<< 3;
      z_q[2]   <= bgjp_pkg::Z_W'(sum2) <<< 3;
    end
  end

  // sin/cos of the three cumulative angles
  bgjp_pkg::trig_t trig [bgjp_pkg::NUM_SEG];
  side_t           side_q [bgjp_pkg::CORDIC_LAT];

  for (genvar k = 0; k < bgjp_pkg::NUM_SEG; k++) begin : g_cordic
    bgjp_cordic u_cordic (
      .clk_i  (clk_i),
      .en_i   (adv),
      .z_i    (z_q[k]),
      .trig_o (trig[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= sm5_sd_q;
      for (int i = 1; i < bgjp_pkg::CORDIC_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // segment offsets: (len * trig + 2^29) >> 30
  logic [bgjp_pkg::LEN_W-1:0] len [bgjp_pkg::NUM_SEG];
  seg_t                       sx_d [bgjp_pkg::NUM_SEG];
  seg_t                       sy_d [bgjp_pkg::NUM_SEG];
  seg_t                       sx_q [bgjp_pkg::NUM_SEG];
  seg_t                       sy_q [bgjp_pkg::NUM_SEG];
  side_t                      seg_sd_q;

  assign len[0] = thigh_q;
  assign len[1] = shank_q;
  assign len[2] = foot_q;

  for (genvar k = 0; k < bgjp_pkg::NUM_SEG; k++) begin : g_seg
    logic signed [bgjp_pkg::PROD_W-1:0] px;
    logic signed [bgjp_pkg::PROD_W-1:0] py;
    logic signed [bgjp_pkg::PROD_W-1:0] ls;

    assign ls = $signed(bgjp_pkg::PROD_W'(len[k]));
    assign px = ls * bgjp_pkg::PROD_W'(trig[k].sin) + $signed(bgjp_pkg::PROD_W'(1) << 29);
    assign py = ls * bgjp_pkg::PROD_W'(trig[k].cos) + $signed(bgjp_pkg::PROD_W'(1) << 29);
    assign sx_d[k] = bgjp_pkg::SEG_W'(px >>> 30);
    assign sy_d[k] = bgjp_pkg::SEG_W'(py >>> 30);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg_sd_q <= side_q[bgjp_pkg::CORDIC_LAT-1];
      sx_q     <= sx_d;
      sy_q     <= sy_d;
    end
  end

  // hip position and prefix sums along the chain
  side_t h_sd_q;
  wide_t hx_q, hy_q;
  wide_t px0_q, px1_q, px2_q;
  wide_t py0_q, py1_q, py2_q;
  wide_t px01, py01;

  assign px01 = bgjp_pkg::WIDE_W'(sx_q[0]) + bgjp_pkg::WIDE_W'(sx_q[1]);
  assign py01 = bgjp_pkg::WIDE_W'(sy_q[0]) + bgjp_pkg::WIDE_W'(sy_q[1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_sd_q <= seg_sd_q;
      hx_q   <= bgjp_pkg::WIDE_W'(body_x_q)
              + (seg_sd_q.left ? $signed(bgjp_pkg::WIDE_W'(stride_q)) : wide_t'(0));
      hy_q   <= bgjp_pkg::WIDE_W'(floor_q) + $signed(bgjp_pkg::WIDE_W'(hip_h_q));
      px0_q  <= bgjp_pkg::WIDE_W'(sx_q[0]);
      py0_q  <= bgjp_pkg::WIDE_W'(sy_q[0]);
      px1_q  <= px01;
      py1_q  <= py01;
      px2_q  <= px01 + bgjp_pkg::WIDE_W'(sx_q[2]);
      py2_q  <= py01 + bgjp_pkg::WIDE_W'(sy_q[2]);
    end
  end

  // output register
  res_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.hip_x   <= bgjp_pkg::sat_pos(hx_q);
      out_q.hip_y   <= bgjp_pkg::sat_pos(hy_q);
      out_q.knee_x  <= bgjp_pkg::sat_pos(hx_q + px0_q);
      out_q.knee_y  <= bgjp_pkg::sat_pos(hy_q - py0_q);
      out_q.ankle_x <= bgjp_pkg::sat_pos(hx_q + px1_q);
      out_q.ankle_y <= bgjp_pkg::sat_pos(hy_q - py1_q);
      out_q.toe_x   <= bgjp_pkg::sat_pos(hx_q + px2_q);
      out_q.toe_y   <= bgjp_pkg::sat_pos(hy_q - py2_q);
      out_q.phase   <= h_sd_q.idx;
      out_q.frac    <= h_sd_q.frac;
    end
  end

  assign out_ch.valid          = vld_q[LAT-1];
  assign out_ch.hip_x          = out_q.hip_x;
  assign out_ch.hip_y          = out_q.hip_y;
  assign out_ch.knee_x         = out_q.knee_x;
  assign out_ch.knee_y         = out_q.knee_y;
  assign out_ch.ankle_x        = out_q.ankle_x;
  assign out_ch.ankle_y        = out_q.ankle_y;
  assign out_ch.toe_x          = out_q.toe_x;
  assign out_ch.toe_y          = out_q.toe_y;
  assign out_ch.gait_phase     = out_q.phase;
  assign out_ch.phase_fraction = out_q.frac;

  `BGJP_ASSERT_ANY(a_rst_empty, !rst_ni |-> !out_ch.valid, "result valid during reset")
  `BGJP_ASSERT(a_phase_range, out_ch.valid |-> (out_ch.gait_phase < bgjp_pkg::NUM_PHASES), "gait phase out of range")
  `BGJP_ASSERT(a_stall_hold, (out_ch.valid && !out_ch.ready) |=> $stable(vld_q), "pipeline moved while stalled")
  `BGJP_ASSERT(a_enter, (in_ch.valid && in_ch.ready) |=> vld_q[0], "accepted sample lost at entry")

endmodule

FILE: design/bgjp_cordic.sv
// ----------------------------------------------------------------------------
// bgjp_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, then one step per stage.
// ----------------------------------------------------------------------------
module bgjp_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [bgjp_pkg::Z_W-1:0]     z_i,
  output bgjp_pkg::trig_t                     trig_o
);

  typedef struct packed {
    logic signed [bgjp_pkg::TRIG_W-1:0] x;
    logic signed [bgjp_pkg::TRIG_W-1:0] y;
    logic signed [bgjp_pkg::Z_W-1:0]    z;
    logic                               neg;
  } cst_t;

  cst_t st_q [bgjp_pkg::CORDIC_LAT];
  cst_t st_d [bgjp_pkg::CORDIC_LAT];

  // angles beyond +-pi/2 are moved by pi and the result negated
  always_comb begin
    st_d[0].x   = bgjp_pkg::CORDIC_GAIN;
    st_d[0].y   = '0;
    st_d[0].z   = z_i;
    st_d[0].neg = 1'b0;
    if (z_i > bgjp_pkg::HALF_PI) begin
      st_d[0].z   = z_i - bgjp_pkg::PI_Z;
      st_d[0].neg = 1'b1;
    end else if (z_i < -bgjp_pkg::HALF_PI) begin
      st_d[0].z   = z_i + bgjp_pkg::PI_Z;
      st_d[0].neg = 1'b1;
    end
  end

  for (genvar k = 1; k < bgjp_pkg::CORDIC_LAT; k++) begin : g_step
    logic signed [bgjp_pkg::TRIG_W-1:0] dx;
    logic signed [bgjp_pkg::TRIG_W-1:0] dy;
    logic signed [bgjp_pkg::Z_W-1:0]    at;
    cst_t                               nx;

    assign dx = st_q[k-1].y >>> (k - 1);
    assign dy = st_q[k-1].x >>> (k - 1);
    assign at = bgjp_pkg::Z_W'(bgjp_pkg::ATAN_Q16[k-1]);

    always_comb begin
      nx.neg = st_q[k-1].neg;
      if (!st_q[k-1].z[bgjp_pkg::Z_W-1]) begin
        nx.x = st_q[k-1].x - dx;
        nx.y = st_q[k-1].y + dy;
        nx.z = st_q[k-1].z - at;
      end else begin
        nx.x = st_q[k-1].x + dx;
        nx.y = st_q[k-1].y - dy;
        nx.z = st_q[k-1].z + at;
      end
      st_d[k] = nx;
      if ((k == bgjp_pkg::CORDIC_LAT - 1) && nx.neg) begin
        st_d[k].x = -nx.x;
        st_d[k].y = -nx.y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign trig_o.sin = st_q[bgjp_pkg::CORDIC_LAT-1].y;
  assign trig_o.cos = st_q[bgjp_pkg::CORDIC_LAT-1].x;

endmodule
